// ===== hw/rtl/brb_pkg.sv =====
package brb_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int MAX_RESULTS  = 64;
    localparam int CMD_W        = 3;
    localparam int CNT_W        = 7;
    localparam int LVL_W        = 9;
    localparam int STS_W        = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REWIND  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd5;

    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STS_W-1:0] ST_BAD   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic run;
        logic pk_rd;
        logic pk_emit;
        logic mv_rd;
        logic mv_wr;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_long;
        logic peek_go;
        logic move_go;
        logic rem_zero;
        logic rem_one;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/brb_ctrl.sv =====
module brb_ctrl import brb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_RUN     = 3'd2;
    localparam logic [2:0] S_PK_RD   = 3'd3;
    localparam logic [2:0] S_PK_EMIT = 3'd4;
    localparam logic [2:0] S_MV_RD   = 3'd5;
    localparam logic [2:0] S_MV_WR   = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.setup = 1'b1;
                n_state     = i_stat.is_long ? S_RUN : S_FINISH;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                if (i_stat.peek_go) begin
                    n_state = S_PK_RD;
                end else if (i_stat.move_go) begin
                    n_state = S_MV_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_PK_RD: begin
                o_cmd.pk_rd = 1'b1;
                n_state     = S_PK_EMIT;
            end
            S_PK_EMIT: begin
                // hold the byte until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.pk_emit = 1'b1;
                    n_state       = i_stat.rem_zero ? S_IDLE : S_PK_RD;
                end
            end
            S_MV_RD: begin
                o_cmd.mv_rd = 1'b1;
                n_state     = S_MV_WR;
            end
            S_MV_WR: begin
                o_cmd.mv_wr = 1'b1;
                n_state     = i_stat.rem_one ? S_FINISH : S_MV_RD;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/brb_dp.sv =====
module brb_dp import brb_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic [CMD_W-1:0] i_command,
    input  logic [7:0]       i_data_byte,
    input  logic [7:0]       i_offset,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [7:0]       o_read_data,
    output logic [LVL_W-1:0] o_fill_level,
    output logic [LVL_W-1:0] o_free_space,
    output logic [STS_W-1:0] o_status,
    output logic             o_last
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = (CW > CNT_W) ? CW : CNT_W;
    localparam int AW = RW + 1;
    localparam logic [IW:0]      CAP_I = (IW + 1)'(CAPACITY);
    localparam logic [AW-1:0]    CAP_A = AW'(CAPACITY);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_RESULTS);

    // a + b mod CAPACITY, for a below CAPACITY and b at most CAPACITY
    function automatic logic [IW-1:0] wrap_add(input logic [IW:0] a, input logic [IW:0] b);
        logic [IW:0] s;
        s = a + b;
        if (s >= CAP_I) begin
            s = s - CAP_I;
        end
        return s[IW-1:0];
    endfunction

    // a - n mod CAPACITY, for a below CAPACITY and n at most CAPACITY
    function automatic logic [IW-1:0] wrap_sub(input logic [IW:0] a, input logic [IW:0] n);
        logic [IW:0] s;
        if (a >= n) begin
            s = a - n;
        end else begin
            s = a + CAP_I - n;
        end
        return s[IW-1:0];
    endfunction

    logic [7:0] mem [CAPACITY];

    logic [CMD_W-1:0] r_command;
    logic [7:0]       r_data_byte;
    logic [7:0]       r_offset;
    logic [CNT_W-1:0] r_count;
    logic [IW-1:0]    r_ri;
    logic [IW-1:0]    r_wi;
    logic [CW-1:0]    r_stored;
    logic [IW-1:0]    r_pos;
    logic [IW-1:0]    r_src;
    logic [IW-1:0]    r_dst;
    logic [IW-1:0]    r_rel;
    logic [RW-1:0]    r_rem;
    logic             r_clip;
    logic [7:0]       r_rdata;
    logic             r_o_valid;
    logic [7:0]       r_o_data;
    logic [LVL_W-1:0] r_o_fill;
    logic [LVL_W-1:0] r_o_free;
    logic [STS_W-1:0] r_o_status;
    logic             r_o_last;

    logic [IW-1:0]    off_tab [256];
    logic [IW-1:0]    off_m;
    logic [AW-1:0]    cnt_a;
    logic [AW-1:0]    sto_a;
    logic [AW-1:0]    rel_a;
    logic [AW-1:0]    space_a;
    logic [AW-1:0]    adv_n;
    logic [AW-1:0]    rew_n;
    logic [RW-1:0]    moves;
    logic [RW-1:0]    peek_n;
    logic             rm_bad;
    logic             full;
    logic             empty;
    logic [IW-1:0]    n_ri;
    logic [IW-1:0]    n_wi;
    logic [CW-1:0]    n_stored;
    logic [STS_W-1:0] fin_status;
    logic [7:0]       fin_data;
    logic             push_wr;
    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    logic [7:0]       mem_wd;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;

    // offset reduced modulo the capacity
    for (genvar g = 0; g < 256; g++) begin : g_off_tab
        assign off_tab[g] = IW'(g % CAPACITY);
    end

    assign off_m   = off_tab[r_offset];
    assign cnt_a   = AW'(r_count);
    assign sto_a   = AW'(r_stored);
    assign rel_a   = AW'(r_rel);
    assign space_a = CAP_A - sto_a;
    assign full    = (sto_a >= CAP_A);
    assign empty   = (r_stored == '0);
    assign adv_n   = (cnt_a > sto_a) ? sto_a : cnt_a;
    assign rew_n   = (cnt_a > space_a) ? space_a : cnt_a;
    assign rm_bad  = (r_count > MAX_C) || ((rel_a + cnt_a) > sto_a);
    assign moves   = RW'(sto_a - rel_a - cnt_a);
    assign peek_n  = (r_count > MAX_C) ? RW'(MAX_RESULTS) : RW'(r_count);

    always_comb begin
        n_ri       = r_ri;
        n_wi       = r_wi;
        n_stored   = r_stored;
        fin_status = ST_OK;
        fin_data   = '0;
        push_wr    = 1'b0;
        case (r_command)
            CMD_PUSH: begin
                if (full) begin
                    fin_status = ST_FULL;
                end else begin
                    push_wr  = 1'b1;
                    n_wi     = wrap_add({1'b0, r_wi}, (IW + 1)'(1));
                    n_stored = CW'(sto_a + AW'(1));
                end
            end
            CMD_POP: begin
                if (empty) begin
                    fin_status = ST_EMPTY;
                end else begin
                    fin_data = r_rdata;
                    n_ri     = wrap_add({1'b0, r_ri}, (IW + 1)'(1));
                    n_stored = CW'(sto_a - AW'(1));
                end
            end
            CMD_ADVANCE: begin
                if (cnt_a > sto_a) begin
                    fin_status = ST_EMPTY;
                end
                n_ri     = wrap_add({1'b0, r_ri}, (IW + 1)'(adv_n));
                n_stored = CW'(sto_a - adv_n);
            end
            CMD_REWIND: begin
                if (cnt_a > space_a) begin
                    fin_status = ST_EMPTY;
                end
                n_ri     = wrap_sub({1'b0, r_ri}, (IW + 1)'(rew_n));
                n_stored = CW'(sto_a + rew_n);
            end
            CMD_PEEK: begin
                // only a zero-length peek ends here
                fin_status = ST_OK;
            end
            CMD_REMOVE: begin
                if (rm_bad) begin
                    fin_status = ST_BAD;
                end else if (r_count != '0) begin
                    n_wi     = wrap_sub({1'b0, r_wi}, (IW + 1)'(cnt_a));
                    n_stored = CW'(sto_a - cnt_a);
                end
            end
            default: begin
                fin_status = ST_BAD;
            end
        endcase
    end

    assign mem_we  = (i_cmd.finish && push_wr) || i_cmd.mv_wr;
    assign mem_wa  = i_cmd.mv_wr ? r_dst : r_wi;
    assign mem_wd  = i_cmd.mv_wr ? r_rdata : r_data_byte;
    assign rd_en   = i_cmd.setup || i_cmd.pk_rd || i_cmd.mv_rd;
    assign rd_addr = i_cmd.pk_rd ? r_pos : (i_cmd.mv_rd ? r_src : r_ri);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command   <= i_command;
            r_data_byte <= i_data_byte;
            r_offset    <= i_offset;
            r_count     <= i_count;
        end
        if (i_cmd.setup) begin
            r_pos <= off_m;
            r_dst <= off_m;
            r_src <= wrap_add({1'b0, off_m}, (IW + 1)'(r_count));
            r_rel <= wrap_sub({1'b0, off_m}, {1'b0, r_ri});
        end
        if (i_cmd.run) begin
            if (r_command == CMD_PEEK) begin
                r_rem  <= peek_n;
                r_clip <= (r_count > MAX_C);
            end else begin
                r_rem <= moves;
            end
        end
        if (i_cmd.pk_rd) begin
            r_pos <= wrap_add({1'b0, r_pos}, (IW + 1)'(1));
            r_rem <= r_rem - RW'(1);
        end
        if (i_cmd.mv_rd) begin
            r_src <= wrap_add({1'b0, r_src}, (IW + 1)'(1));
        end
        if (i_cmd.mv_wr) begin
            r_dst <= wrap_add({1'b0, r_dst}, (IW + 1)'(1));
            r_rem <= r_rem - RW'(1);
        end
        if (i_cmd.pk_emit) begin
            r_o_data   <= r_rdata;
            r_o_fill   <= LVL_W'(r_stored);
            r_o_free   <= LVL_W'(space_a);
            r_o_status <= r_clip ? ST_BAD : ST_OK;
            r_o_last   <= (r_rem == '0);
        end
        if (i_cmd.finish) begin
            r_o_data   <= fin_data;
            r_o_fill   <= LVL_W'(n_stored);
            r_o_free   <= LVL_W'(CAP_A - AW'(n_stored));
            r_o_status <= fin_status;
            r_o_last   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ri      <= '0;
            r_wi      <= '0;
            r_stored  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_ri     <= n_ri;
                r_wi     <= n_wi;
                r_stored <= n_stored;
            end
            if (i_cmd.pk_emit || i_cmd.finish) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_stat.is_long  = (r_command == CMD_PEEK) || (r_command == CMD_REMOVE);
    assign o_stat.peek_go  = (r_command == CMD_PEEK) && (r_count != '0);
    assign o_stat.move_go  = (r_command == CMD_REMOVE) && !rm_bad && (r_count != '0)
                             && (moves != '0);
    assign o_stat.rem_zero = (r_rem == '0);
    assign o_stat.rem_one  = (r_rem == RW'(1));
    assign o_stat.out_free = !r_o_valid || !i_stall;

    assign o_valid      = r_o_valid;
    assign o_read_data  = r_o_data;
    assign o_fill_level = r_o_fill;
    assign o_free_space = r_o_free;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;

endmodule

// ===== hw/rtl/byte_ring_buffer_with_compaction.sv =====
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_command, i_data_byte, i_offset, i_count
// result    out        o_valid / i_stall  o_read_data, o_fill_level, o_free_space,
//                                         o_status, o_last
//
// Push, pop, advance, rewind, bad command: load, decode and finish states; the decode
// state reads the byte store and the finish state loads the output register.
// Peek of n bytes: one store read and one result beat per byte (count zero: one beat).
// Remove: the bytes behind the removed range are shifted down, each read, then written.
// Reset clears indices, fill count and output valid; the byte store is not cleared.
// A held result blocks only the next beat; a new item is taken while it waits.
module byte_ring_buffer_with_compaction import brb_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CMD_W-1:0] i_command,
    input  logic [7:0]       i_data_byte,
    input  logic [7:0]       i_offset,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_read_data,
    output logic [LVL_W-1:0] o_fill_level,
    output logic [LVL_W-1:0] o_free_space,
    output logic [STS_W-1:0] o_status,
    output logic             o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     busy;

    brb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    brb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .i_offset     (i_offset),
        .i_count      (i_count),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_fill_level (o_fill_level),
        .o_free_space (o_free_space),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    assign o_stall = busy;

endmodule

// ===== hw/rtl/brb_chk.sv =====
module brb_chk import brb_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [7:0]       o_read_data,
    input logic [LVL_W-1:0] o_fill_level,
    input logic [LVL_W-1:0] o_free_space,
    input logic [STS_W-1:0] o_status,
    input logic             o_last
);

    localparam logic [LVL_W-1:0] CAP_L = LVL_W'(CAPACITY);

    // an accepted input beat keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input beat accepted while the block was not taken busy");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data) && $stable(o_fill_level)
            && $stable(o_free_space) && $stable(o_status) && $stable(o_last))
        else $error("result beat changed while stalled");

    a_level_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> LVL_W'(o_fill_level + o_free_space) == CAP_L)
        else $error("fill level and free space do not add up to capacity");

    // a dropped push only happens on a full buffer
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_fill_level == CAP_L) && (o_free_space == '0))
        else $error("push dropped while space remained");

    // an empty status (empty pop, clipped advance or rewind) leaves the buffer drained or completely filled
    a_clip_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_fill_level == '0) || (o_free_space == '0))
        else $error("clipped result away from an edge of the buffer");

endmodule

bind byte_ring_buffer_with_compaction brb_chk #(.CAPACITY(CAPACITY)) u_brb_chk (.*);

// ===== tb/tb_byte_ring_buffer_with_compaction.sv =====
module tb_byte_ring_buffer_with_compaction;
    import brb_pkg::*;

    localparam int RING_DEPTH   = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 200;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [7:0]       data;
        logic [7:0]       off;
        logic [CNT_W-1:0] cnt;
    } t_ring_cmd;

    typedef struct packed {
        logic [7:0]       data;
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] room;
        logic [STS_W-1:0] sts;
        logic             last;
    } t_ring_result;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             o_stall;
    logic [CMD_W-1:0] i_command   = CMD_PUSH;
    logic [7:0]       i_data_byte = 8'h00;
    logic [7:0]       i_offset    = 8'h00;
    logic [CNT_W-1:0] i_count     = '0;
    logic             o_valid;
    logic             i_stall     = 1'b0;
    logic [7:0]       o_read_data;
    logic [LVL_W-1:0] o_fill_level;
    logic [LVL_W-1:0] o_free_space;
    logic [STS_W-1:0] o_status;
    logic             o_last;

    // shadow copy of the ring, advanced as each command is queued
    logic [7:0] ring_mem [0:RING_DEPTH-1];
    bit         ring_written [0:RING_DEPTH-1];
    logic [7:0] ring_rd;
    logic [7:0] ring_wr;
    int         ring_fill;

    t_ring_cmd    cmd_backlog[$];
    t_ring_result awaited_results[$];

    bit feed_on   = 1'b0;
    bit feed_calm = 1'b0;
    bit sink_calm = 1'b0;
    bit in_took   = 1'b0;
    int feed_gap  = 0;
    int sink_hold = 0;
    int cycle_count = 0;
    int fail_count  = 0;

    byte_ring_buffer_with_compaction DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .i_offset     (i_offset),
        .i_count      (i_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_fill_level (o_fill_level),
        .o_free_space (o_free_space),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic int idle_len(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic t_ring_result ring_result(logic [7:0] data, logic [STS_W-1:0] sts,
                                                 logic last);
        t_ring_result r;
        int room;
        room    = RING_DEPTH - ring_fill;
        r.data  = data;
        r.level = ring_fill[LVL_W-1:0];
        r.room  = room[LVL_W-1:0];
        r.sts   = sts;
        r.last  = last;
        return r;
    endfunction

    // A command is unsafe if it would read a store entry that holds no written byte.
    function automatic bit ring_cmd_safe(t_ring_cmd c);
        int n;
        int moves;
        logic [7:0] rel;
        logic [7:0] pos;
        case (c.cmd)
            CMD_POP: begin
                return ring_fill == 0 || ring_written[ring_rd];
            end
            CMD_PEEK: begin
                n = (c.cnt > MAX_RESULTS) ? MAX_RESULTS : int'(c.cnt);
                for (int i = 0; i < n; i++) begin
                    pos = c.off + 8'(i);
                    if (!ring_written[pos]) return 1'b0;
                end
            end
            CMD_REMOVE: begin
                rel = c.off - ring_rd;
                if (c.cnt <= MAX_RESULTS && int'(rel) + int'(c.cnt) <= ring_fill
                        && c.cnt != 0) begin
                    moves = ring_fill - int'(rel) - int'(c.cnt);
                    for (int i = 0; i < moves; i++) begin
                        pos = c.off + 8'(c.cnt) + 8'(i);
                        if (!ring_written[pos]) return 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return 1'b1;
    endfunction

    task automatic predict_ring_results(t_ring_cmd c);
        int n;
        int moves;
        logic [7:0] rel;
        logic [7:0] dst;
        logic [7:0] src;
        logic [7:0] got;
        logic [STS_W-1:0] sts;
        sts = ST_OK;
        case (c.cmd)
            CMD_PUSH: begin
                if (ring_fill >= RING_DEPTH) begin
                    sts = ST_FULL;
                end else begin
                    ring_mem[ring_wr]     = c.data;
                    ring_written[ring_wr] = 1'b1;
                    ring_wr++;
                    ring_fill++;
                end
                awaited_results.push_back(ring_result(8'h00, sts, 1'b1));
            end
            CMD_POP: begin
                if (ring_fill == 0) begin
                    awaited_results.push_back(ring_result(8'h00, ST_EMPTY, 1'b1));
                end else begin
                    got = ring_mem[ring_rd];
                    ring_rd++;
                    ring_fill--;
                    awaited_results.push_back(ring_result(got, ST_OK, 1'b1));
                end
            end
            CMD_ADVANCE: begin
                n = c.cnt;
                if (n > ring_fill) begin
                    n   = ring_fill;
                    sts = ST_EMPTY;
                end
                ring_rd   = ring_rd + n[7:0];
                ring_fill = ring_fill - n;
                awaited_results.push_back(ring_result(8'h00, sts, 1'b1));
            end
            CMD_REWIND: begin
                n = c.cnt;
                if (n > RING_DEPTH - ring_fill) begin
                    n   = RING_DEPTH - ring_fill;
                    sts = ST_EMPTY;
                end
                ring_rd   = ring_rd - n[7:0];
                ring_fill = ring_fill + n;
                awaited_results.push_back(ring_result(8'h00, sts, 1'b1));
            end
            CMD_PEEK: begin
                if (c.cnt == 0) begin
                    awaited_results.push_back(ring_result(8'h00, ST_OK, 1'b1));
                end else begin
                    n = c.cnt;
                    if (n > MAX_RESULTS) begin
                        n   = MAX_RESULTS;
                        sts = ST_BAD;
                    end
                    for (int i = 0; i < n; i++) begin
                        got = ring_mem[c.off + 8'(i)];
                        awaited_results.push_back(ring_result(got, sts, i == n - 1));
                    end
                end
            end
            CMD_REMOVE: begin
                rel = c.off - ring_rd;
                if (c.cnt > MAX_RESULTS || int'(rel) + int'(c.cnt) > ring_fill) begin
                    awaited_results.push_back(ring_result(8'h00, ST_BAD, 1'b1));
                end else begin
                    if (c.cnt != 0) begin
                        // close the gap: shift the later bytes down
                        moves = ring_fill - int'(rel) - int'(c.cnt);
                        dst   = c.off;
                        src   = c.off + 8'(c.cnt);
                        for (int i = 0; i < moves; i++) begin
                            ring_mem[dst]     = ring_mem[src];
                            ring_written[dst] = ring_written[src];
                            dst++;
                            src++;
                        end
                        ring_wr   = ring_wr - 8'(c.cnt);
                        ring_fill = ring_fill - int'(c.cnt);
                    end
                    awaited_results.push_back(ring_result(8'h00, ST_OK, 1'b1));
                end
            end
            default: begin
                awaited_results.push_back(ring_result(8'h00, ST_BAD, 1'b1));
            end
        endcase
    endtask

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [7:0] data, logic [7:0] off,
                             logic [CNT_W-1:0] cnt);
        t_ring_cmd c;
        c.cmd  = cmd;
        c.data = data;
        c.off  = off;
        c.cnt  = cnt;
        // turn a read of unwritten bytes into a push
        if (!ring_cmd_safe(c)) c.cmd = CMD_PUSH;
        predict_ring_results(c);
        cmd_backlog.push_back(c);
    endtask

    task automatic queue_random_cmd();
        int pick;
        int k;
        int roll;
        logic [CMD_W-1:0] cmd;
        logic [7:0]       off;
        logic [CNT_W-1:0] cnt;
        pick = $urandom_range(0, 99);
        off  = 8'($urandom);
        cnt  = 7'($urandom_range(0, 16));
        if (pick < 20) begin
            cmd = CMD_PUSH;
        end else if (pick < 32) begin
            cmd = CMD_POP;
        end else if (pick < 44) begin
            cmd = CMD_ADVANCE;
            if ($urandom_range(0, 3) == 0) cnt = 7'($urandom);
        end else if (pick < 56) begin
            cmd = CMD_REWIND;
            cnt = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
        end else if (pick < 78) begin
            cmd = CMD_PEEK;
            k   = $urandom_range(1, 90);
            if ($urandom_range(0, 3) != 0) off = ring_wr - 8'(k);
            roll = $urandom_range(0, 9);
            if (roll == 0) cnt = '0;
            else if (roll < 3) cnt = 7'($urandom_range(65, 127));
            else cnt = 7'($urandom_range(1, 64));
        end else if (pick < 96) begin
            cmd = CMD_REMOVE;
            if ($urandom_range(0, 4) != 0) begin
                off = ring_rd + 8'($urandom_range(0, ring_fill));
                cnt = 7'($urandom_range(0, 12));
            end else begin
                cnt = 7'($urandom);
            end
        end else begin
            cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
        end
        queue_cmd(cmd, 8'($urandom), off, cnt);
    endtask

    task automatic check_field(string name, logic [LVL_W-1:0] want, logic [LVL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        in_took     <= i_valid && !o_stall;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // command driver
    always @(negedge i_clk) begin
        t_ring_cmd c;
        if (!feed_on) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_took) begin
            if (feed_gap > 0) begin
                feed_gap <= feed_gap - 1;
                i_valid  <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                c = cmd_backlog.pop_front();
                i_command   <= c.cmd;
                i_data_byte <= c.data;
                i_offset    <= c.off;
                i_count     <= c.cnt;
                i_valid     <= 1'b1;
                feed_gap    <= idle_len(feed_calm);
                if ($urandom_range(0, 39) == 0) feed_calm <= !feed_calm;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result-side back-pressure
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            i_stall   <= 1'b1;
            sink_hold <= sink_hold - 1;
        end else begin
            i_stall   <= 1'b0;
            sink_hold <= idle_len(sink_calm);
        end
        if ($urandom_range(0, 199) == 0) sink_calm <= !sink_calm;
    end

    // result checker
    always @(posedge i_clk) begin
        t_ring_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual data %0h level %0d st %0d",
                         $time, o_read_data, o_fill_level, o_status);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("read_data", LVL_W'(want.data), LVL_W'(o_read_data));
                check_field("fill_level", want.level, o_fill_level);
                check_field("free_space", want.room, o_free_space);
                check_field("status", LVL_W'(want.sts), LVL_W'(o_status));
                check_field("last", LVL_W'(want.last), LVL_W'(o_last));
            end
        end
    end

    initial begin
        int made;
        int burst;
        ring_rd   = 8'h00;
        ring_wr   = 8'h00;
        ring_fill = 0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_mem[i]     = 8'h00;
            ring_written[i] = 1'b0;
        end

        queue_cmd(CMD_POP, 8'h00, 8'h00, 7'd0);         // empty pop
        queue_cmd(CMD_ADVANCE, 8'h00, 8'h00, 7'd127);   // advance past stored data
        queue_cmd(CMD_PUSH, 8'h00, 8'h00, 7'd0);
        queue_cmd(CMD_PUSH, 8'hFF, 8'hFF, 7'd0);
        queue_cmd(CMD_PUSH, 8'h3C, 8'h00, 7'd0);
        queue_cmd(CMD_PEEK, 8'h00, 8'h00, 7'd0);        // zero-length peek
        queue_cmd(CMD_POP, 8'h00, 8'h00, 7'd0);
        queue_cmd(CMD_REWIND, 8'h00, 8'h00, 7'd1);
        queue_cmd(CMD_REMOVE, 8'h00, 8'h01, 7'd1);      // mid removal with shift
        queue_cmd(CMD_REMOVE, 8'h00, 8'h80, 7'd5);      // range outside the data
        queue_cmd(CMD_REMOVE, 8'h00, 8'h00, 7'd127);    // count above the cap
        queue_cmd(CMD_SPARE_B, 8'h00, 8'h00, 7'd0);
        queue_cmd(CMD_REWIND, 8'h00, 8'h00, 7'd5);      // read index wraps below zero
        queue_cmd(CMD_REMOVE, 8'h00, 8'hFD, 7'd4);      // write index wraps below zero
        queue_cmd(CMD_ADVANCE, 8'h00, 8'h00, 7'd2);
        queue_cmd(CMD_PUSH, 8'h81, 8'h00, 7'd0);
        queue_cmd(CMD_PUSH, 8'h7E, 8'h00, 7'd0);
        queue_cmd(CMD_PEEK, 8'h00, 8'hFD, 7'd4);        // peek across the top
        queue_cmd(CMD_REWIND, 8'h00, 8'h00, 7'd127);
        queue_cmd(CMD_REWIND, 8'h00, 8'h00, 7'd127);    // clips at the free space
        queue_cmd(CMD_PUSH, 8'hAA, 8'h00, 7'd0);        // full, dropped
        queue_cmd(CMD_POP, 8'h00, 8'h00, 7'd0);
        queue_cmd(CMD_ADVANCE, 8'h00, 8'h00, 7'd127);
        queue_cmd(CMD_ADVANCE, 8'h00, 8'h00, 7'd127);
        queue_cmd(CMD_REMOVE, 8'h00, 8'hFF, 7'd0);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    burst = $urandom_range(4, 30);
                    repeat (burst) queue_cmd(CMD_PUSH, 8'($urandom), 8'($urandom), 7'($urandom));
                    made += burst;
                end
                3: begin
                    burst = $urandom_range(2, 10);
                    repeat (burst) queue_cmd(CMD_POP, 8'($urandom), 8'($urandom), 7'($urandom));
                    made += burst;
                end
                default: begin
                    queue_random_cmd();
                    made++;
                end
            endcase
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        feed_on <= 1'b1;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/brb_pkg.sv
hw/rtl/brb_ctrl.sv
hw/rtl/brb_dp.sv
hw/rtl/byte_ring_buffer_with_compaction.sv
hw/rtl/brb_chk.sv
tb/tb_byte_ring_buffer_with_compaction.sv
